/* hw/rtl/bbpq_pkg.sv */
// Shared types and constants for the bit-box point quantizer.
// Used by bbpq_ctrl, bbpq_dp and bit_box_point_quantizer; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbpq_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_MAX_DIMS   = 3;
    localparam int NUM_DIM_REGS   = 3;
    localparam int COORD_W        = 32;
    localparam int STEP_W         = 31;
    localparam int DIV_STEPS      = 32;
    localparam int MAX_BITS       = 33;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 120;
    localparam int CFG_DATA_W     = 32;

    localparam logic [1:0] REG_DIMS_IN_USE = 2'd0;
    localparam logic [1:0] REG_ERROR_STEP  = 2'd1;

    typedef enum logic [4:0] {
        S_IDLE, S_FILL,
        S_MM_RD, S_MM_UPD, S_MID,
        S_NR_RD, S_NR_DIFF, S_NR_SQ, S_NR_ACC, S_NR_CMP,
        S_BT_RD, S_BT_HALF, S_BT_ITER,
        S_EM_RD_C, S_EM_CAP_C, S_EM_RD_P, S_EM_DIFF, S_EM_DIV, S_EM_MUL, S_EM_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LATCH_STEP, OP_MM_UPD, OP_MID,
        OP_NR_DIFF, OP_NR_SQ, OP_NR_ACC, OP_NR_CMP,
        OP_BT_HALF, OP_BT_ITER, OP_BT_SAVE,
        OP_CAP_C, OP_CODE_DIFF, OP_DIV_STEP, OP_MUL,
        OP_OUT_CENTER, OP_OUT_BITS, OP_OUT_CODE
    } t_dp_op;

    typedef enum logic [1:0] {
        PH_CENTER, PH_BITS, PH_CODE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_CENTER = 2'd0,
        KIND_BITS   = 2'd1,
        KIND_CODE   = 2'd2,
        KIND_UNPRED = 2'd3
    } t_kind;

    typedef struct packed {
        t_dp_op     op;
        logic       we;
        logic       wr_zero;
        logic [1:0] dim;
        logic       first;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic bt_done;
    } t_dp_sts;

endpackage

`default_nettype wire

/* hw/rtl/bbpq_dp.sv */
// Datapath of the bit-box point quantizer: point memory, box registers,
// squared-distance unit, bit-count search, restoring divider and output register.
// Depends on bbpq_pkg; driven by bbpq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module bbpq_dp #(
    parameter int MAX_POINTS = bbpq_pkg::DEF_MAX_POINTS,
    parameter int MAX_DIMS   = bbpq_pkg::DEF_MAX_DIMS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire bbpq_pkg::t_dp_cmd                      i_cmd,
    input  wire logic [$clog2(MAX_POINTS*MAX_DIMS)-1:0] i_addr,
    input  wire logic [$clog2(MAX_POINTS)-1:0]          i_pt,
    input  wire logic [31:0]                            i_coord,
    input  wire logic [30:0]                            i_error_step,
    input  wire logic                                   i_out_ready,
    output bbpq_pkg::t_dp_sts                           o_sts,
    output logic [$clog2(MAX_POINTS)-1:0]               o_nearest,
    output logic                                        o_out_valid,
    output bbpq_pkg::t_kind                             o_out_kind,
    output logic [5:0]                                  o_out_pt,
    output logic [1:0]                                  o_out_dim,
    output logic [31:0]                                 o_out_center,
    output logic [5:0]                                  o_out_bits,
    output logic [32:0]                                 o_out_code,
    output logic [33:0]                                 o_out_recon,
    output logic                                        o_out_last
);
    import bbpq_pkg::*;

    localparam int DEPTH = MAX_POINTS * MAX_DIMS;
    localparam int PW    = $clog2(MAX_POINTS);

    logic [31:0]        r_mem [DEPTH];
    logic [31:0]        r_rd_data;
    logic signed [31:0] r_min [NUM_DIM_REGS];
    logic signed [31:0] r_max [NUM_DIM_REGS];
    logic signed [31:0] r_mid [NUM_DIM_REGS];
    logic [32:0]        r_nabs;
    logic [65:0]        r_sq;
    logic [65:0]        r_acc;
    logic [65:0]        r_best;
    logic [PW-1:0]      r_nearest;
    logic [31:0]        r_half;
    logic [33:0]        r_t;
    logic [5:0]         r_m;
    logic [5:0]         r_bits [NUM_DIM_REGS];
    logic [30:0]        r_step;
    logic signed [31:0] r_c;
    logic               r_neg;
    logic [30:0]        r_rem;
    logic [31:0]        r_quo;
    logic [61:0]        r_prod;

    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [5:0]         r_out_pt;
    logic [1:0]         r_out_dim;
    logic [31:0]        r_out_center;
    logic [5:0]         r_out_bits;
    logic [32:0]        r_out_code;
    logic [33:0]        r_out_recon;
    logic               r_out_last;

    logic signed [31:0] v_mid [NUM_DIM_REGS];
    logic signed [32:0] v_sum [NUM_DIM_REGS];
    logic signed [32:0] v_rd_x;
    logic signed [32:0] v_ndiff;
    logic [32:0]        v_nabs;
    logic signed [32:0] v_h1;
    logic signed [32:0] v_h2;
    logic [31:0]        v_half;
    logic [33:0]        v_t_next;
    logic signed [32:0] v_cdiff;
    logic [31:0]        v_cabs;
    logic [31:0]        v_trial;
    logic               v_ge;
    logic [30:0]        v_rem_next;
    logic [30:0]        v_qmag;
    logic signed [34:0] v_q;
    logic [5:0]         v_m;
    logic signed [34:0] v_base;
    logic signed [34:0] v_lim;
    logic signed [34:0] v_cd;
    logic signed [34:0] v_p2;
    logic signed [34:0] v_rec;
    logic               v_unpred;

    always_comb begin
        for (int d = 0; d < NUM_DIM_REGS; d++) begin
            v_sum[d] = {r_min[d][31], r_min[d]} + {r_max[d][31], r_max[d]};
            v_mid[d] = v_sum[d][32:1];
        end
        v_rd_x   = {r_rd_data[31], r_rd_data};
        v_ndiff  = v_rd_x - {r_mid[i_cmd.dim][31], r_mid[i_cmd.dim]};
        v_nabs   = v_ndiff[32] ? 33'(-v_ndiff) : 33'(v_ndiff);
        v_h1     = v_rd_x - {r_min[i_cmd.dim][31], r_min[i_cmd.dim]};
        v_h2     = {r_max[i_cmd.dim][31], r_max[i_cmd.dim]} - v_rd_x;
        v_half   = (v_h1 > v_h2) ? 32'(v_h1) : 32'(v_h2);
        v_t_next = {r_t[32:0], 1'b0} + 34'(r_step);
        v_cdiff  = v_rd_x - {r_c[31], r_c};
        v_cabs   = v_cdiff[32] ? 32'(-v_cdiff) : 32'(v_cdiff);
        v_trial  = {r_rem, r_quo[31]};
        v_ge     = (v_trial >= {1'b0, r_step});
        v_rem_next = v_ge ? 31'(v_trial - {1'b0, r_step}) : v_trial[30:0];
        v_qmag   = r_quo[31:1];
        v_q      = r_neg ? -signed'(35'(v_qmag)) : signed'(35'(v_qmag));
        v_m      = r_bits[i_cmd.dim];
        v_base   = (v_m == 6'd0) ? 35'sd0 : signed'(35'(1) << (v_m - 6'd1));
        v_lim    = signed'((35'(1) << v_m) - 35'(1));
        v_cd     = v_base + v_q;
        v_unpred = (v_cd < 35'sd1) || (v_cd > v_lim);
        v_p2     = signed'(35'({r_prod, 1'b0}));
        v_rec    = signed'({{3{r_c[31]}}, r_c}) + (r_neg ? -v_p2 : v_p2);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_addr] <= i_cmd.wr_zero ? '0 : i_coord;
        end
        r_rd_data <= r_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_OUT_CENTER || i_cmd.op == OP_OUT_BITS ||
                     i_cmd.op == OP_OUT_CODE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH_STEP: begin
                r_step <= (i_error_step == '0) ? 31'd1 : i_error_step;
            end
            OP_MM_UPD: begin
                if (i_cmd.first || signed'(r_rd_data) < r_min[i_cmd.dim]) begin
                    r_min[i_cmd.dim] <= signed'(r_rd_data);
                end
                if (i_cmd.first || signed'(r_rd_data) > r_max[i_cmd.dim]) begin
                    r_max[i_cmd.dim] <= signed'(r_rd_data);
                end
            end
            OP_MID: begin
                for (int d = 0; d < NUM_DIM_REGS; d++) begin
                    r_mid[d] <= v_mid[d];
                end
                r_acc <= '0;
            end
            OP_NR_DIFF: r_nabs <= v_nabs;
            OP_NR_SQ:   r_sq   <= r_nabs * r_nabs;
            OP_NR_ACC:  r_acc  <= r_acc + r_sq;
            OP_NR_CMP: begin
                if (i_cmd.first || r_acc < r_best) begin
                    r_best    <= r_acc;
                    r_nearest <= i_pt;
                end
                r_acc <= '0;
            end
            OP_BT_HALF: begin
                r_half <= v_half;
                r_t    <= '0;
                r_m    <= '0;
            end
            OP_BT_ITER: begin
                r_t <= v_t_next;
                r_m <= r_m + 6'd1;
            end
            OP_BT_SAVE:   r_bits[i_cmd.dim] <= r_m;
            OP_CAP_C:     r_c <= signed'(r_rd_data);
            OP_CODE_DIFF: begin
                r_neg <= v_cdiff[32];
                r_quo <= v_cabs;
                r_rem <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= v_rem_next;
                r_quo <= {r_quo[30:0], v_ge};
            end
            OP_MUL: r_prod <= v_qmag * r_step;
            OP_OUT_CENTER: begin
                r_out_kind   <= KIND_CENTER;
                r_out_pt     <= 6'(i_pt);
                r_out_dim    <= i_cmd.dim;
                r_out_center <= r_c;
                r_out_bits   <= '0;
                r_out_code   <= '0;
                r_out_recon  <= '0;
                r_out_last   <= i_cmd.last;
            end
            OP_OUT_BITS: begin
                r_out_kind   <= KIND_BITS;
                r_out_pt     <= 6'(i_pt);
                r_out_dim    <= i_cmd.dim;
                r_out_center <= '0;
                r_out_bits   <= v_m;
                r_out_code   <= '0;
                r_out_recon  <= '0;
                r_out_last   <= i_cmd.last;
            end
            OP_OUT_CODE: begin
                r_out_kind   <= v_unpred ? KIND_UNPRED : KIND_CODE;
                r_out_pt     <= 6'(i_pt);
                r_out_dim    <= i_cmd.dim;
                r_out_center <= '0;
                r_out_bits   <= '0;
                r_out_code   <= v_unpred ? '0 : v_cd[32:0];
                r_out_recon  <= v_unpred ? '0 : v_rec[33:0];
                r_out_last   <= i_cmd.last;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.bt_done  = ({2'b00, r_half} <= r_t) || (r_m == 6'(MAX_BITS));
    assign o_nearest      = r_nearest;
    assign o_out_valid    = r_out_valid;
    assign o_out_kind     = r_out_kind;
    assign o_out_pt       = r_out_pt;
    assign o_out_dim      = r_out_dim;
    assign o_out_center   = r_out_center;
    assign o_out_bits     = r_out_bits;
    assign o_out_code     = r_out_code;
    assign o_out_recon    = r_out_recon;
    assign o_out_last     = r_out_last;

    a_unpred_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_UNPRED) |-> (r_out_code == '0 && r_out_recon == '0))
        else $error("unpredictable item carries a code");

endmodule

`default_nettype wire

/* hw/rtl/bbpq_ctrl.sv */
// Controller of the bit-box point quantizer: load bookkeeping, box-build
// sequence and emit order. Depends on bbpq_pkg; commands bbpq_dp.
`timescale 1ns / 1ps
`default_nettype none

module bbpq_ctrl #(
    parameter int MAX_POINTS = bbpq_pkg::DEF_MAX_POINTS,
    parameter int MAX_DIMS   = bbpq_pkg::DEF_MAX_DIMS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic                                   i_action,
    input  wire logic                                   i_last_of_point,
    input  wire logic                                   i_last_point,
    input  wire logic [1:0]                             i_dims_in_use,
    input  wire bbpq_pkg::t_dp_sts                      i_sts,
    input  wire logic [$clog2(MAX_POINTS)-1:0]          i_nearest,
    output bbpq_pkg::t_dp_cmd                           o_cmd,
    output logic [$clog2(MAX_POINTS*MAX_DIMS)-1:0]      o_addr,
    output logic [$clog2(MAX_POINTS)-1:0]               o_pt
);
    import bbpq_pkg::*;

    localparam int AW = $clog2(MAX_POINTS * MAX_DIMS);
    localparam int PW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_cur_dim, n_cur_dim;
    logic          r_set_closed, n_set_closed;
    logic          r_box_ready, n_box_ready;
    logic [1:0]    r_box_dims, n_box_dims;
    logic [PW-1:0] r_i, n_i;
    logic [1:0]    r_d, n_d;
    t_phase        r_phase, n_phase;
    logic [PW-1:0] r_k, n_k;
    logic          r_emit_done, n_emit_done;
    logic [4:0]    r_div_cnt, n_div_cnt;

    logic          v_newset;
    logic [CW-1:0] v_cnt;
    logic [1:0]    v_cd;
    logic [1:0]    v_cd_next;
    logic [PW-1:0] v_pt;
    logic [1:0]    v_dim;
    logic [PW-1:0] v_code_pt;
    logic [1:0]    v_eff_dims;
    logic          v_d_last;
    logic          v_i_last;
    logic          v_k_last;
    logic          v_one_point;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_cur_dim    <= '0;
            r_set_closed <= 1'b0;
            r_box_ready  <= 1'b0;
            r_box_dims   <= '0;
            r_i          <= '0;
            r_d          <= '0;
            r_phase      <= PH_CENTER;
            r_k          <= '0;
            r_emit_done  <= 1'b0;
            r_div_cnt    <= '0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_cur_dim    <= n_cur_dim;
            r_set_closed <= n_set_closed;
            r_box_ready  <= n_box_ready;
            r_box_dims   <= n_box_dims;
            r_i          <= n_i;
            r_d          <= n_d;
            r_phase      <= n_phase;
            r_k          <= n_k;
            r_emit_done  <= n_emit_done;
            r_div_cnt    <= n_div_cnt;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cur_dim    = r_cur_dim;
        n_set_closed = r_set_closed;
        n_box_ready  = r_box_ready;
        n_box_dims   = r_box_dims;
        n_i          = r_i;
        n_d          = r_d;
        n_phase      = r_phase;
        n_k          = r_k;
        n_emit_done  = r_emit_done;
        n_div_cnt    = r_div_cnt;
        o_cmd        = '{op: OP_NONE, we: 1'b0, wr_zero: 1'b0, dim: r_d,
                         first: 1'b0, last: 1'b0};
        o_in_ready   = 1'b0;
        v_pt         = r_i;
        v_dim        = r_d;

        v_newset    = r_set_closed || r_box_ready;
        v_cnt       = v_newset ? '0 : r_count;
        v_cd        = v_newset ? '0 : r_cur_dim;
        v_cd_next   = v_cd + 2'd1;
        v_code_pt   = (r_k < i_nearest) ? r_k : r_k + PW'(1);
        v_eff_dims  = (i_dims_in_use == 2'd0) ? 2'd1 :
                      (i_dims_in_use > 2'(MAX_DIMS)) ? 2'(MAX_DIMS) : i_dims_in_use;
        v_d_last    = (r_d == r_box_dims - 2'd1);
        v_i_last    = (CW'(r_i) == r_count - CW'(1));
        v_k_last    = (CW'(r_k) == r_count - CW'(2));
        v_one_point = (r_count == CW'(1));

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                v_pt       = PW'(v_cnt);
                v_dim      = v_cd;
                if (i_in_valid && !i_action) begin
                    n_set_closed = (v_newset ? 1'b0 : r_set_closed) || i_last_point;
                    n_box_ready  = v_newset ? 1'b0 : r_box_ready;
                    n_emit_done  = 1'b0;
                    n_count      = v_cnt;
                    n_cur_dim    = v_cd;
                    if (v_cnt < CW'(MAX_POINTS)) begin
                        if (v_cd < 2'(MAX_DIMS)) begin
                            o_cmd.we  = 1'b1;
                            n_cur_dim = v_cd_next;
                        end
                        if (i_last_of_point || i_last_point) begin
                            if (v_cd < 2'(MAX_DIMS - 1)) begin
                                n_state = S_FILL;
                            end else begin
                                n_count   = v_cnt + CW'(1);
                                n_cur_dim = '0;
                            end
                        end
                    end
                end else if (i_in_valid && i_action) begin
                    if (!r_box_ready) begin
                        if (r_count != '0) begin
                            o_cmd.op   = OP_LATCH_STEP;
                            n_box_dims = v_eff_dims;
                            n_i        = '0;
                            n_d        = '0;
                            n_state    = S_MM_RD;
                        end
                    end else if (!r_emit_done) begin
                        n_state = (r_phase == PH_BITS) ? S_EM_OUT : S_EM_RD_C;
                    end
                end
            end
            S_FILL: begin
                v_pt          = PW'(r_count);
                v_dim         = r_cur_dim;
                o_cmd.we      = 1'b1;
                o_cmd.wr_zero = 1'b1;
                if (r_cur_dim == 2'(MAX_DIMS - 1)) begin
                    n_count   = r_count + CW'(1);
                    n_cur_dim = '0;
                    n_state   = S_IDLE;
                end else begin
                    n_cur_dim = r_cur_dim + 2'd1;
                end
            end
            S_MM_RD: n_state = S_MM_UPD;
            S_MM_UPD: begin
                o_cmd.op    = OP_MM_UPD;
                o_cmd.first = (r_i == '0);
                n_state     = S_MM_RD;
                if (v_i_last) begin
                    n_i = '0;
                    if (v_d_last) begin
                        n_d     = '0;
                        n_state = S_MID;
                    end else begin
                        n_d = r_d + 2'd1;
                    end
                end else begin
                    n_i = r_i + PW'(1);
                end
            end
            S_MID: begin
                o_cmd.op = OP_MID;
                n_state  = S_NR_RD;
            end
            S_NR_RD: n_state = S_NR_DIFF;
            S_NR_DIFF: begin
                o_cmd.op = OP_NR_DIFF;
                n_state  = S_NR_SQ;
            end
            S_NR_SQ: begin
                o_cmd.op = OP_NR_SQ;
                n_state  = S_NR_ACC;
            end
            S_NR_ACC: begin
                o_cmd.op = OP_NR_ACC;
                if (v_d_last) begin
                    n_state = S_NR_CMP;
                end else begin
                    n_d     = r_d + 2'd1;
                    n_state = S_NR_RD;
                end
            end
            S_NR_CMP: begin
                o_cmd.op    = OP_NR_CMP;
                o_cmd.first = (r_i == '0);
                n_d         = '0;
                if (v_i_last) begin
                    n_i     = '0;
                    n_state = S_BT_RD;
                end else begin
                    n_i     = r_i + PW'(1);
                    n_state = S_NR_RD;
                end
            end
            S_BT_RD: begin
                v_pt    = i_nearest;
                n_state = S_BT_HALF;
            end
            S_BT_HALF: begin
                o_cmd.op = OP_BT_HALF;
                n_state  = S_BT_ITER;
            end
            S_BT_ITER: begin
                if (i_sts.bt_done) begin
                    o_cmd.op = OP_BT_SAVE;
                    if (v_d_last) begin
                        n_box_ready = 1'b1;
                        n_emit_done = 1'b0;
                        n_phase     = PH_CENTER;
                        n_d         = '0;
                        n_k         = '0;
                        n_state     = S_EM_RD_C;
                    end else begin
                        n_d     = r_d + 2'd1;
                        n_state = S_BT_RD;
                    end
                end else begin
                    o_cmd.op = OP_BT_ITER;
                end
            end
            S_EM_RD_C: begin
                v_pt    = i_nearest;
                n_state = S_EM_CAP_C;
            end
            S_EM_CAP_C: begin
                o_cmd.op = OP_CAP_C;
                n_state  = (r_phase == PH_CENTER) ? S_EM_OUT : S_EM_RD_P;
            end
            S_EM_RD_P: begin
                v_pt    = v_code_pt;
                n_state = S_EM_DIFF;
            end
            S_EM_DIFF: begin
                o_cmd.op  = OP_CODE_DIFF;
                n_div_cnt = '0;
                n_state   = S_EM_DIV;
            end
            S_EM_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_div_cnt == 5'(DIV_STEPS - 1)) begin
                    n_state = S_EM_MUL;
                end else begin
                    n_div_cnt = r_div_cnt + 5'd1;
                end
            end
            S_EM_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = S_EM_OUT;
            end
            S_EM_OUT: begin
                v_pt = (r_phase == PH_CODE) ? v_code_pt : i_nearest;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                    case (r_phase)
                        PH_CENTER: begin
                            o_cmd.op = OP_OUT_CENTER;
                            if (v_d_last) begin
                                n_phase = PH_BITS;
                                n_d     = '0;
                            end else begin
                                n_d = r_d + 2'd1;
                            end
                        end
                        PH_BITS: begin
                            o_cmd.op   = OP_OUT_BITS;
                            o_cmd.last = v_d_last && v_one_point;
                            if (v_d_last) begin
                                n_d         = '0;
                                n_k         = '0;
                                n_phase     = PH_CODE;
                                n_emit_done = v_one_point;
                            end else begin
                                n_d = r_d + 2'd1;
                            end
                        end
                        default: begin
                            o_cmd.op   = OP_OUT_CODE;
                            o_cmd.last = v_d_last && v_k_last;
                            if (v_d_last) begin
                                n_d = '0;
                                if (v_k_last) begin
                                    n_emit_done = 1'b1;
                                end else begin
                                    n_k = r_k + PW'(1);
                                end
                            end else begin
                                n_d = r_d + 2'd1;
                            end
                        end
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.dim = v_dim;
    end

    assign o_addr = AW'(AW'(v_pt) * AW'(MAX_DIMS)) + AW'(v_dim);
    assign o_pt   = v_pt;

    a_box_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_box_ready |-> (r_count != '0))
        else $error("box built over an empty set");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_done_needs_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_done |-> r_box_ready)
        else $error("emit finished without a box");

    a_emit_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EM_OUT && i_sts.out_free) |=> (r_state == S_IDLE))
        else $error("emit did not return to idle");

endmodule

`default_nettype wire

/* hw/rtl/bit_box_point_quantizer.sv */
// Bit-box point quantizer, top level: stream ports, configuration registers,
// controller and datapath. Depends on bbpq_pkg, bbpq_ctrl and bbpq_dp.
//
// Usage: requests arrive on s_axis. tuser[0] = 0 loads one coordinate
// (tdata[31:0], tdata[32] closes the point, tlast closes the set); tuser[0] = 1
// fetches the next result. Results leave on m_axis with the kind in tuser and
// tlast on the final item of the run. Registers are to be written on the cfg
// channel (index 0 dims in use, index 1 error step) only while the block is
// idle; the block itself does not enforce this. A point that closes short has
// its missing dimensions zero-filled before the next request is taken. The
// first fetch after loading builds the box: a min/max pass, the nearest-point
// search (one memory read and one 33x33 multiply per coordinate, one compare
// per point), then the bit-count search per dimension, before the first item
// is formed. Later fetches: a code item waits on the 32-step restoring
// divider, while center and bit-count items do not.
// Only one request is in work at a time; s_axis_tready is high only while idle.
// The output register holds a result while m_axis_tready is low; the next
// request is still taken, and its result waits until the register frees.
// Reset clears the set, the box and the output; dims in use reads 3 and the
// step 1. The point memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module bit_box_point_quantizer #(
    parameter int MAX_POINTS = bbpq_pkg::DEF_MAX_POINTS,
    parameter int MAX_DIMS   = bbpq_pkg::DEF_MAX_DIMS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [39:0]  s_axis_tdata,   // coord[31:0], last_of_point[32], zero
    input  wire logic         s_axis_tlast,   // last_point
    input  wire logic [0:0]   s_axis_tuser,   // action[0]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // point_number[5:0], dim_number[7:6], center_value[39:8], bit_count[45:40],
    // quant_code[78:46], recon_value[112:79], zero
    output logic [119:0]      m_axis_tdata,
    output logic              m_axis_tlast,   // last_of_run
    output logic [1:0]        m_axis_tuser,   // kind[1:0]
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);
    import bbpq_pkg::*;

    localparam int AW = $clog2(MAX_POINTS * MAX_DIMS);
    localparam int PW = $clog2(MAX_POINTS);

    logic [1:0]  r_dims_in_use;
    logic [30:0] r_error_step;

    t_dp_cmd     w_cmd;
    t_dp_sts     w_sts;
    logic [AW-1:0] w_addr;
    logic [PW-1:0] w_pt;
    logic [PW-1:0] w_nearest;
    t_kind       w_kind;
    logic [5:0]  w_pt_out;
    logic [1:0]  w_dim;
    logic [31:0] w_center;
    logic [5:0]  w_bits;
    logic [32:0] w_code;
    logic [33:0] w_recon;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims_in_use <= 2'd3;
            r_error_step  <= 31'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DIMS_IN_USE: r_dims_in_use <= i_cfg_data[1:0];
                REG_ERROR_STEP:  r_error_step  <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    bbpq_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIMS   (MAX_DIMS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_axis_tvalid),
        .o_in_ready      (s_axis_tready),
        .i_action        (s_axis_tuser[0]),
        .i_last_of_point (s_axis_tdata[32]),
        .i_last_point    (s_axis_tlast),
        .i_dims_in_use   (r_dims_in_use),
        .i_sts           (w_sts),
        .i_nearest       (w_nearest),
        .o_cmd           (w_cmd),
        .o_addr          (w_addr),
        .o_pt            (w_pt)
    );

    bbpq_dp #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIMS   (MAX_DIMS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_addr       (w_addr),
        .i_pt         (w_pt),
        .i_coord      (s_axis_tdata[31:0]),
        .i_error_step (r_error_step),
        .i_out_ready  (m_axis_tready),
        .o_sts        (w_sts),
        .o_nearest    (w_nearest),
        .o_out_valid  (m_axis_tvalid),
        .o_out_kind   (w_kind),
        .o_out_pt     (w_pt_out),
        .o_out_dim    (w_dim),
        .o_out_center (w_center),
        .o_out_bits   (w_bits),
        .o_out_code   (w_code),
        .o_out_recon  (w_recon),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, w_recon, w_code, w_bits, w_center, w_dim, w_pt_out};
    assign m_axis_tuser = w_kind;

endmodule

`default_nettype wire

/* bench/bbpq_scoreboard.sv */
// Checker for the bit-box point quantizer: watches the request, result and
// register channels, predicts every result and compares it. Depends on bbpq_pkg.
`timescale 1ns / 1ps

module bbpq_scoreboard (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [39:0]  s_axis_tdata,
    input  wire logic         s_axis_tlast,
    input  wire logic [0:0]   s_axis_tuser,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [119:0] m_axis_tdata,
    input  wire logic         m_axis_tlast,
    input  wire logic [1:0]   m_axis_tuser,
    input  wire logic         i_cfg_valid,
    input  wire logic         o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);
    import bbpq_pkg::*;

    localparam int NPTS = DEF_MAX_POINTS;
    localparam int NDIM = DEF_MAX_DIMS;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  pnum;
        logic [1:0]  dnum;
        logic [31:0] center;
        logic [5:0]  bits;
        logic [32:0] code;
        logic [33:0] recon;
        logic        last;
    } quant_item_t;

    quant_item_t   quant_q[$];
    longint        coords[NPTS*NDIM];
    int unsigned   pt_count, open_dim, emit_pos, near_pt, box_dims;
    int unsigned   dim_bits[NDIM];
    bit            set_closed, box_built;
    logic [1:0]    dims_reg;
    logic [30:0]   step_reg;
    longint        box_step;
    int            fails;

    assign o_fail_count = fails;
    assign o_pending    = quant_q.size();

    function automatic void store_coord(logic [31:0] raw, bit lop, bit lp);
        if (set_closed || box_built) begin
            pt_count = 0;
            open_dim = 0;
            box_built = 0;
            emit_pos = 0;
            set_closed = 0;
        end
        if (pt_count < NPTS) begin
            if (open_dim < NDIM) begin
                coords[pt_count*NDIM + open_dim] = longint'(signed'(raw));
                open_dim++;
            end
            if (lop || lp) begin
                for (; open_dim < NDIM; open_dim++)
                    coords[pt_count*NDIM + open_dim] = 0;
                pt_count++;
                open_dim = 0;
            end
        end
        if (lp)
            set_closed = 1;
    endfunction

    function automatic void build_box();
        longint       mn[NDIM], mx[NDIM], mid[NDIM];
        logic [127:0] best, acc;
        longint       df, c, h;
        logic [63:0]  mag, half;
        int unsigned  m;
        box_dims = (dims_reg == 0) ? 1 : (dims_reg > NDIM) ? NDIM : dims_reg;
        box_step = (step_reg == 0) ? 1 : longint'(step_reg);
        best = '0;
        for (int d = 0; d < box_dims; d++) begin
            mn[d] = coords[d];
            mx[d] = coords[d];
            for (int i = 1; i < pt_count; i++) begin
                if (coords[i*NDIM + d] < mn[d]) mn[d] = coords[i*NDIM + d];
                if (coords[i*NDIM + d] > mx[d]) mx[d] = coords[i*NDIM + d];
            end
            mid[d] = (mn[d] + mx[d]) >>> 1;
        end
        near_pt = 0;
        for (int i = 0; i < pt_count; i++) begin
            acc = '0;
            for (int d = 0; d < box_dims; d++) begin
                df = coords[i*NDIM + d] - mid[d];
                mag = (df < 0) ? -df : df;
                acc += {64'd0, mag * mag};
            end
            if (i == 0 || acc < best) begin
                best = acc;
                near_pt = i;
            end
        end
        for (int d = 0; d < box_dims; d++) begin
            c = coords[near_pt*NDIM + d];
            h = (c - mn[d] > mx[d] - c) ? c - mn[d] : mx[d] - c;
            half = h;
            m = 0;
            while (m < 33 && ((64'd1 << m) - 64'd1) * 64'(box_step) < half)
                m++;
            dim_bits[d] = m;
        end
        box_built = 1;
        emit_pos = 0;
    endfunction

    function automatic bit next_item(output quant_item_t it);
        int unsigned total, p, r, k, d, pt, m;
        longint      c, q, base, cd, lim;
        it = '0;
        if (!box_built) begin
            if (pt_count == 0)
                return 0;
            build_box();
        end
        total = box_dims * (pt_count + 1);
        if (emit_pos >= total)
            return 0;
        p = emit_pos;
        if (p < box_dims) begin
            d = p;
            pt = near_pt;
            it.kind = KIND_CENTER;
            it.center = 32'(coords[pt*NDIM + d]);
        end else if (p < 2*box_dims) begin
            d = p - box_dims;
            pt = near_pt;
            it.kind = KIND_BITS;
            it.bits = 6'(dim_bits[d]);
        end else begin
            r = p - 2*box_dims;
            k = r / box_dims;
            d = r % box_dims;
            pt = (k < near_pt) ? k : k + 1;
            m = dim_bits[d];
            c = coords[near_pt*NDIM + d];
            q = ((coords[pt*NDIM + d] - c) / box_step) / 2;
            base = (m == 0) ? 0 : (64'sd1 <<< (m - 1));
            cd = base + q;
            lim = (64'sd1 <<< m) - 1;
            if (cd < 1 || cd > lim) begin
                it.kind = KIND_UNPRED;
            end else begin
                it.kind = KIND_CODE;
                it.code = 33'(cd);
                it.recon = 34'(c + q * 2 * box_step);
            end
        end
        emit_pos++;
        it.pnum = 6'(pt);
        it.dnum = 2'(d);
        it.last = (emit_pos == total);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        quant_item_t exp_it, got_it;
        if (!i_rst_n) begin
            quant_q.delete();
            pt_count = 0;
            open_dim = 0;
            emit_pos = 0;
            near_pt = 0;
            box_built = 0;
            set_closed = 0;
            box_dims = 0;
            box_step = 1;
            dims_reg = 2'd3;
            step_reg = 31'd1;
            fails = 0;
            for (int d = 0; d < NDIM; d++)
                dim_bits[d] = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_it = '{kind: m_axis_tuser, pnum: m_axis_tdata[5:0],
                           dnum: m_axis_tdata[7:6], center: m_axis_tdata[39:8],
                           bits: m_axis_tdata[45:40], code: m_axis_tdata[78:46],
                           recon: m_axis_tdata[112:79], last: m_axis_tlast};
                if (quant_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result: kind %0d point %0d dim %0d",
                                 got_it.kind, got_it.pnum, got_it.dnum);
                end else begin
                    exp_it = quant_q.pop_front();
                    if (got_it.kind !== exp_it.kind || got_it.pnum !== exp_it.pnum ||
                        got_it.dnum !== exp_it.dnum || got_it.center !== exp_it.center ||
                        got_it.bits !== exp_it.bits || got_it.code !== exp_it.code ||
                        got_it.recon !== exp_it.recon || got_it.last !== exp_it.last ||
                        m_axis_tdata[119:113] !== '0) begin
                        fails++;
                        if (fails <= 10) begin
                            $display({"expected kind %0d pt %0d dim %0d ctr %h",
                                      " bits %0d code %h rec %h last %b"},
                                     exp_it.kind, exp_it.pnum, exp_it.dnum,
                                     exp_it.center, exp_it.bits, exp_it.code,
                                     exp_it.recon, exp_it.last);
                            $display({"actual   kind %0d pt %0d dim %0d ctr %h",
                                      " bits %0d code %h rec %h last %b"},
                                     got_it.kind, got_it.pnum, got_it.dnum,
                                     got_it.center, got_it.bits, got_it.code,
                                     got_it.recon, got_it.last);
                        end
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_DIMS_IN_USE)
                    dims_reg = i_cfg_data[1:0];
                else if (i_cfg_index == REG_ERROR_STEP)
                    step_reg = i_cfg_data[30:0];
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser[0] == 1'b0)
                    store_coord(s_axis_tdata[31:0], s_axis_tdata[32], s_axis_tlast);
                else if (next_item(exp_it))
                    quant_q.insert(quant_q.size(), exp_it);
            end
        end
    end

endmodule

/* bench/bit_box_point_quantizer_test.sv */
// Top of the quantizer bench: clock, reset, request and register stimulus under
// varying idle and stall patterns, and the verdict. Depends on bbpq_pkg,
// bbpq_scoreboard and bit_box_point_quantizer.
`timescale 1ns / 1ps

module bit_box_point_quantizer_test;
    import bbpq_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int ITEM_GOAL   = 2000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;
    logic         s_axis_tlast;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [119:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic [1:0]   m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;
    int           fail_count, pending;
    int           send_idle, recv_stall, req_count;
    int unsigned  dims_now;
    bit           hold_req, hold_on;
    longint       set_base;
    int unsigned  set_spread, set_mode;

    bit_box_point_quantizer dut (.*);

    bbpq_scoreboard checker_u (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tlast, .s_axis_tuser, .m_axis_tvalid, .m_axis_tready,
        .m_axis_tdata, .m_axis_tlast, .m_axis_tuser, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_index, .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hold the result side off for a long stretch once asked
    initial begin
        hold_on = 0;
        wait (hold_req);
        @(posedge i_clk);
        hold_on <= 1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_on && ($urandom_range(99) >= recv_stall);
    end

    task automatic send_req(bit fetch, logic [31:0] coord, bit lop, bit lp);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= fetch;
        s_axis_tdata <= {7'd0, lop, coord};
        s_axis_tlast <= lp;
        do @(posedge i_clk); while (!s_axis_tready);
        req_count++;
    endtask

    task automatic fetch_req();
        send_req(1'b1, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic [31:0] dims_val, logic [31:0] step_val);
        write_reg(REG_DIMS_IN_USE, dims_val);
        write_reg(REG_ERROR_STEP, step_val);
        dims_now = (dims_val[1:0] == 0) ? 1 : dims_val[1:0];
    endtask

    function automatic logic [31:0] pick_coord();
        longint v;
        case (set_mode)
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                        : 32'h7fff_ffff - $urandom_range(3);
            default: begin
                v = set_base + longint'($urandom_range(set_spread)) - set_spread / 2;
                return 32'(v);
            end
        endcase
    endfunction

    task automatic run_set(bit well_formed, int n_pts);
        int unsigned n_co, kept, n_fetch;
        bit lop, lp, open_tail;
        set_mode = ($urandom_range(9) == 0) ? 0 : ($urandom_range(19) == 0) ? 1 : 2;
        set_base = longint'(signed'(32'($urandom))) / ($urandom_range(1) ? 1 : 65536);
        set_spread = $urandom_range(1) ? $urandom_range(4000) : $urandom_range(40);
        open_tail = !well_formed && $urandom_range(3) == 0;
        kept = 0;
        for (int p = 0; p < n_pts; p++) begin
            n_co = well_formed ? dims_now : $urandom_range(1, 5);
            for (int c = 0; c < n_co; c++) begin
                lop = (c == n_co - 1);
                lp = lop && (p == n_pts - 1) && !open_tail;
                if (!well_formed && $urandom_range(15) == 0)
                    lp = 1'($urandom_range(1));
                if (open_tail && p == n_pts - 1)
                    lop = 0;
                send_req(1'b0, pick_coord(), lop, lp);
                if ((lop || lp) && kept < DEF_MAX_POINTS)
                    kept++;
                if (lp)
                    break;
            end
            if (lp)
                break;
        end
        n_fetch = dims_now * (kept + 1) + $urandom_range(2);
        if (!well_formed && $urandom_range(3) == 0)
            n_fetch = $urandom_range(n_fetch);
        for (int f = 0; f < n_fetch; f++)
            send_req(1'b1, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic directed_part();
        fetch_req();
        send_req(1'b0, 32'h8000_0000, 1'b0, 1'b0);
        send_req(1'b0, 32'h7fff_ffff, 1'b0, 1'b0);
        send_req(1'b0, 32'd0, 1'b1, 1'b0);
        send_req(1'b0, 32'h7fff_ffff, 1'b0, 1'b0);
        send_req(1'b0, 32'h8000_0000, 1'b0, 1'b0);
        send_req(1'b0, 32'd5, 1'b0, 1'b0);
        send_req(1'b0, 32'hffff_ffff, 1'b1, 1'b0);
        send_req(1'b0, 32'd7, 1'b1, 1'b0);
        send_req(1'b0, 32'd3, 1'b0, 1'b0);
        send_req(1'b0, 32'hffff_fff0, 1'b0, 1'b1);
        for (int f = 0; f < 16; f++)
            send_req(1'b1, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tlast = 0;
        s_axis_tuser = '0;
        i_cfg_valid = 0;
        i_cfg_index = REG_DIMS_IN_USE;
        i_cfg_data = '0;
        hold_req = 0;
        send_idle = 0;
        recv_stall = 0;
        req_count = 0;
        dims_now = 3;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_part();
        settle();
        // all points equal gives zero bits and unpredictable codes
        set_regs(32'd2, 32'h7fff_ffff);
        for (int p = 0; p < 3; p++) begin
            send_req(1'b0, 32'd9, 1'b0, 1'b0);
            send_req(1'b0, 32'd9, 1'b1, p == 2);
        end
        for (int f = 0; f < 8; f++)
            send_req(1'b1, $urandom, 1'b0, 1'b0);
        settle();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  set_regs(32'd3, 32'd1); end
                1: begin send_idle = 84; recv_stall = 0;  set_regs(32'hffff_fff1, 32'd0); end
                2: begin send_idle = 0;  recv_stall = 84; set_regs(32'd0, 32'h8000_0005); end
                default: begin send_idle = 17; recv_stall = 17; set_regs(32'd2, 32'd37); end
            endcase
            if (ph == 0) begin
                hold_req = 1;
                run_set(1, 20);
            end
            while (req_count < ITEM_GOAL * (ph + 1) / 4) begin
                if ($urandom_range(4) == 0)
                    run_set(0, $urandom_range(1, 8));
                else if ($urandom_range(30) == 0)
                    run_set(1, $urandom_range(60, 70));
                else
                    run_set(1, $urandom_range(1, 8));
                if ($urandom_range(5) == 0) begin
                    settle();
                    set_regs($urandom, $urandom_range(1) ? $urandom_range(1, 300) : $urandom);
                end
            end
            settle();
        end
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
